// ===== design/lkrp_pkg.sv =====
// shared types and constants of the key reconciliation packer
package lkrp_pkg;

  // fixed field widths
  localparam int ELEMENT_W = 16;
  localparam int BYTE_W    = 8;
  localparam int MODE_W    = 2;
  localparam int BITS_W    = 4;
  localparam int APB_DW    = 32;
  localparam int APB_AW    = 3;

  // mode register codes; the unused code behaves as plain key rounding
  localparam logic [MODE_W-1:0] MODE_HINT     = 2'd0;
  localparam logic [MODE_W-1:0] MODE_KEY      = 2'd1;
  localparam logic [MODE_W-1:0] MODE_KEY_HINT = 2'd2;

  // register index of mode
  localparam logic REG_MODE = 1'b0;

  // word leaving the packer towards the output register
  typedef struct packed {
    logic              emit;
    logic [BYTE_W-1:0] data;
    logic              last;
  } pack_result_t;

endpackage

// ===== design/lkrp_cfg.sv =====
// apb register file holding the mode register
module lkrp_cfg (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [lkrp_pkg::APB_AW-1:0]     paddr,
  input  logic [lkrp_pkg::APB_DW-1:0]     pwdata,
  output logic [lkrp_pkg::APB_DW-1:0]     prdata,
  output logic                            pready,
  output logic [lkrp_pkg::MODE_W-1:0]     mode
);

  logic reg_sel;
  logic wr_en;

  // word address decode: bit 2 picks the register slot
  assign reg_sel = (paddr[lkrp_pkg::APB_AW-1] == lkrp_pkg::REG_MODE);
  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready && reg_sel;

  // mode register
  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= lkrp_pkg::MODE_HINT;
    end else if (wr_en) begin
      mode <= pwdata[lkrp_pkg::MODE_W-1:0];
    end
  end

  // read back
  always_comb begin
    prdata = '0;
    if (reg_sel) begin
      prdata[lkrp_pkg::MODE_W-1:0] = mode;
    end
  end

endmodule

// ===== design/lkrp_chunk.sv =====
// rounding of one element into its key chunk, plus its hint bit
module lkrp_chunk #(
  parameter int KEY_BITS   = 4,
  parameter int SHIFT_BITS = 11
) (
  input  logic [lkrp_pkg::ELEMENT_W-1:0] element,
  input  logic                           hint,
  input  logic                           with_hint,
  output logic                           hint_b,
  output logic [KEY_BITS-1:0]            chunk
);

  localparam logic [lkrp_pkg::ELEMENT_W-1:0] ROUNDER =
    lkrp_pkg::ELEMENT_W'(1) << (SHIFT_BITS - 1);
  localparam logic [lkrp_pkg::ELEMENT_W-1:0] BIAS_STEP =
    lkrp_pkg::ELEMENT_W'(1) << (SHIFT_BITS - 2);

  logic                           bias_on;
  logic [lkrp_pkg::ELEMENT_W-1:0] rounded;
  logic [lkrp_pkg::ELEMENT_W-1:0] biased;
  logic [lkrp_pkg::ELEMENT_W-1:0] shifted;

  assign hint_b  = element[SHIFT_BITS-1];

  // bias only where the two bits under the rounding point disagree
  assign bias_on = with_hint && (element[SHIFT_BITS-1] != element[SHIFT_BITS-2]);
  assign rounded = element + ROUNDER;

  // signed bias, everything modulo 2^16
  always_comb begin
    biased = rounded;
    if (bias_on) begin
      if (hint) begin
        biased = rounded + BIAS_STEP;
      end else begin
        biased = rounded - BIAS_STEP;
      end
    end
  end

  assign shifted = biased >> SHIFT_BITS;
  assign chunk   = shifted[KEY_BITS-1:0];

endmodule

// ===== design/lkrp_packer.sv =====
// byte accumulator, bit count and element count of the current matrix
module lkrp_packer #(
  parameter int KEY_BITS   = 4,
  parameter int MATRIX_DIM = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          go,
  input  logic [lkrp_pkg::MODE_W-1:0]   mode,
  input  logic                          hint_b,
  input  logic [KEY_BITS-1:0]           chunk,
  output lkrp_pkg::pack_result_t        res
);

  localparam int TOTAL = MATRIX_DIM * MATRIX_DIM;
  localparam int CNT_W = $clog2(TOTAL);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(TOTAL - 1);
  localparam logic [lkrp_pkg::BITS_W-1:0] FULL = lkrp_pkg::BITS_W'(lkrp_pkg::BYTE_W);
  localparam logic [lkrp_pkg::BITS_W-1:0] STEP = lkrp_pkg::BITS_W'(KEY_BITS);

  logic [CNT_W-1:0]              element_count;
  logic [CNT_W-1:0]              element_count_next;
  logic [lkrp_pkg::BYTE_W-1:0]   byte_accumulator;
  logic [lkrp_pkg::BYTE_W-1:0]   byte_accumulator_next;
  logic [lkrp_pkg::BITS_W-1:0]   bits_in_byte;
  logic [lkrp_pkg::BITS_W-1:0]   bits_in_byte_next;

  logic                          is_hint;
  logic                          last;
  logic                          done;
  logic [lkrp_pkg::BYTE_W-1:0]   acc_add;
  logic [lkrp_pkg::BITS_W-1:0]   bits_add;
  logic [lkrp_pkg::BYTE_W-1:0]   acc_pad;
  logic [lkrp_pkg::BITS_W-1:0]   bits_pad;

  assign is_hint = (mode == lkrp_pkg::MODE_HINT);
  assign last    = (element_count == CNT_LAST);

  // put this element's contribution into the byte
  always_comb begin
    if (is_hint) begin
      acc_add  = byte_accumulator |
                 (lkrp_pkg::BYTE_W'(hint_b) << bits_in_byte[2:0]);
      bits_add = bits_in_byte + lkrp_pkg::BITS_W'(1);
    end else begin
      acc_add  = (byte_accumulator << KEY_BITS) | lkrp_pkg::BYTE_W'(chunk);
      bits_add = bits_in_byte + STEP;
    end
  end

  assign done = (bits_add >= FULL);

  // end of matrix in a key byte: pad with zero chunks until full
  always_comb begin
    acc_pad  = acc_add;
    bits_pad = bits_add;
    for (int i = 0; i < lkrp_pkg::BYTE_W - 1; i++) begin
      if (bits_pad < FULL) begin
        acc_pad  = acc_pad << KEY_BITS;
        bits_pad = bits_pad + STEP;
      end
    end
  end

  // result word
  always_comb begin
    res.emit = done || last;
    res.last = last;
    res.data = (last && !done && !is_hint) ? acc_pad : acc_add;
  end

  // next state
  always_comb begin
    element_count_next = last ? '0 : element_count + CNT_W'(1);
    if (res.emit) begin
      byte_accumulator_next = '0;
      bits_in_byte_next     = '0;
    end else begin
      byte_accumulator_next = acc_add;
      bits_in_byte_next     = bits_add;
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      element_count    <= '0;
      byte_accumulator <= '0;
      bits_in_byte     <= '0;
    end else if (go) begin
      element_count    <= element_count_next;
      byte_accumulator <= byte_accumulator_next;
      bits_in_byte     <= bits_in_byte_next;
    end
  end

endmodule

// ===== design/lwe_key_reconciliation_packer_unit.sv =====
// top level of the lwe key reconciliation packer
//
//   port group   role     handshake            payload
//   in           sink     in_valid / in_stall  element, hint
//   out          source   out_valid / out_stall out_byte, last_byte
//   apb          slave    psel/penable/pready  paddr, pwdata, prdata
//
// one element is taken every cycle while in_stall is low; the element that completes a
// byte passes the input register, then the output register, before the byte appears
// the packing state is one byte accumulator with its bit and element counts, updated in the input-register stage
// a stalled output holds the byte; input stalls only when a byte is due and the
// output register is still full and stalled
// synchronous reset clears the handshake state, the packing state and mode
module lwe_key_reconciliation_packer_unit #(
  parameter int KEY_BITS   = 4,
  parameter int SHIFT_BITS = 11,
  parameter int MATRIX_DIM = 8
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [lkrp_pkg::ELEMENT_W-1:0]      element,
  input  logic                                hint,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [lkrp_pkg::BYTE_W-1:0]         out_byte,
  output logic                                last_byte,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [lkrp_pkg::APB_AW-1:0]         paddr,
  input  logic [lkrp_pkg::APB_DW-1:0]         pwdata,
  output logic [lkrp_pkg::APB_DW-1:0]         prdata,
  output logic                                pready
);

  logic [lkrp_pkg::MODE_W-1:0]    mode;
  logic                           s1_valid;
  logic [lkrp_pkg::ELEMENT_W-1:0] s1_element;
  logic                           s1_hint;
  logic                           s1_go;
  logic                           in_take;
  logic                           hint_b;
  logic [KEY_BITS-1:0]            chunk;
  lkrp_pkg::pack_result_t         pk;

  // configuration registers
  lkrp_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .mode    (mode)
  );

  // per-element rounding
  lkrp_chunk #(
    .KEY_BITS   (KEY_BITS),
    .SHIFT_BITS (SHIFT_BITS)
  ) u_chunk (
    .element   (s1_element),
    .hint      (s1_hint),
    .with_hint (mode == lkrp_pkg::MODE_KEY_HINT),
    .hint_b    (hint_b),
    .chunk     (chunk)
  );

  // byte packing state
  lkrp_packer #(
    .KEY_BITS   (KEY_BITS),
    .MATRIX_DIM (MATRIX_DIM)
  ) u_packer (
    .clk    (clk),
    .rst    (rst),
    .go     (s1_go),
    .mode   (mode),
    .hint_b (hint_b),
    .chunk  (chunk),
    .res    (pk)
  );

  // the held element moves on unless it makes a byte that has nowhere to go
  assign s1_go    = s1_valid && (!pk.emit || !out_valid || !out_stall);
  assign in_stall = s1_valid && !s1_go;
  assign in_take  = in_valid && !in_stall;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_take) begin
      s1_valid <= 1'b1;
    end else if (s1_go) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_element <= element;
      s1_hint    <= hint;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_go && pk.emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && pk.emit) begin
      out_byte  <= pk.data;
      last_byte <= pk.last;
    end
  end

`ifndef SYNTHESIS
  // a due byte blocked by a full output keeps its element in place
  a_hold_blocked: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && pk.emit && out_valid && out_stall) |=>
      (s1_valid && $stable(s1_element) && $stable(s1_hint)))
    else $error("blocked element left the input register");

  // a new output word only ever comes from a completed byte
  a_no_invented: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall) |=> (!out_valid || $past(s1_go && pk.emit)))
    else $error("output word appeared without a completed byte");

  // a completed byte lands in the output register unchanged
  a_byte_lands: assert property (@(posedge clk) disable iff (rst)
    (s1_go && pk.emit) |=>
      (out_valid && out_byte == $past(pk.data) && last_byte == $past(pk.last)))
    else $error("completed byte not captured");
`endif

endmodule

// ===== tb/sv/lwe_key_reconciliation_packer_unit_test.sv =====
// self-checking testbench for the lwe key reconciliation packer unit
`timescale 1ns / 1ps

module lwe_key_reconciliation_packer_unit_test;

  localparam int ELEMENT_W = lkrp_pkg::ELEMENT_W;
  localparam int BYTE_W    = lkrp_pkg::BYTE_W;
  localparam int MODE_W    = lkrp_pkg::MODE_W;
  localparam int APB_DW    = lkrp_pkg::APB_DW;
  localparam int APB_AW    = lkrp_pkg::APB_AW;

  localparam int KEY_BITS    = 4;
  localparam int SHIFT_BITS  = 11;
  localparam int MATRIX_DIM  = 8;
  localparam int MATRIX_ELEMS = MATRIX_DIM * MATRIX_DIM;
  localparam int RANDOM_WORDS = 1700;
  localparam int SETTLE_CYCLES = 8;

  localparam logic [ELEMENT_W-1:0] ROUND_HALF = ELEMENT_W'(1) << (SHIFT_BITS - 1);
  localparam logic [ELEMENT_W-1:0] BIAS_STEP  = ELEMENT_W'(1) << (SHIFT_BITS - 2);
  localparam logic [ELEMENT_W-1:0] LOW_MASK   = (ELEMENT_W'(1) << SHIFT_BITS) - 1'b1;
  // code not listed in the package, decoded as plain key rounding
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

  typedef struct packed {
    logic [ELEMENT_W-1:0] value;
    logic                 hint;
  } element_word_t;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              last;
  } packed_byte_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [ELEMENT_W-1:0] element = '0;
  logic                 hint = 1'b0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [BYTE_W-1:0]    out_byte;
  logic                 last_byte;
  logic                 psel = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite = 1'b0;
  logic [APB_AW-1:0]    paddr = '0;
  logic [APB_DW-1:0]    pwdata = '0;
  logic [APB_DW-1:0]    prdata;
  logic                 pready;

  lwe_key_reconciliation_packer_unit #(
    .KEY_BITS  (KEY_BITS),
    .SHIFT_BITS(SHIFT_BITS),
    .MATRIX_DIM(MATRIX_DIM)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .element  (element),
    .hint     (hint),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_byte (out_byte),
    .last_byte(last_byte),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  // words waiting to be sent and bytes the packer still owes
  element_word_t pending_elements[$];
  packed_byte_t  due_bytes[$];
  int            mismatches = 0;

  // own copy of the packer state
  logic [MODE_W-1:0] shadow_mode = lkrp_pkg::MODE_HINT;
  logic [7:0]        elems_in_matrix = '0;
  logic [BYTE_W-1:0] byte_acc = '0;
  int                acc_fill = 0;

  task automatic flag_mismatch(input string what);
    mismatches++;
    $display("%0t ns  mismatch: %s", $time, what);
  endtask

  function automatic logic [KEY_BITS-1:0] rounded_chunk(input logic [ELEMENT_W-1:0] v,
                                                        input logic h, input logic biased);
    logic [ELEMENT_W-1:0] sum;
    sum = v + ROUND_HALF;
    // bias only where the two bits below the rounding point disagree
    if (biased && (v[SHIFT_BITS-1] != v[SHIFT_BITS-2]))
      sum = h ? sum + BIAS_STEP : sum - BIAS_STEP;
    return KEY_BITS'(sum >> SHIFT_BITS);
  endfunction

  // advance the packing state by one element and note any byte it completes
  task automatic pack_element(input logic [ELEMENT_W-1:0] v, input logic h);
    logic         closes_matrix;
    logic         byte_ready;
    packed_byte_t word_out;
    closes_matrix = (int'(elems_in_matrix) + 1) >= MATRIX_ELEMS;
    if (shadow_mode == lkrp_pkg::MODE_HINT) begin
      byte_acc = byte_acc | (BYTE_W'(v[SHIFT_BITS-1]) << (acc_fill % 8));
      acc_fill += 1;
    end else begin
      byte_acc = (byte_acc << KEY_BITS) |
                 BYTE_W'(rounded_chunk(v, h, shadow_mode == lkrp_pkg::MODE_KEY_HINT));
      acc_fill += KEY_BITS;
    end
    byte_ready = acc_fill >= 8;
    // matrix ending inside a byte: flush it, key bytes padded with zero chunks
    if (closes_matrix && !byte_ready) begin
      if (shadow_mode != lkrp_pkg::MODE_HINT) begin
        while (acc_fill < 8) begin
          byte_acc = byte_acc << KEY_BITS;
          acc_fill += KEY_BITS;
        end
      end
      byte_ready = 1'b1;
    end
    elems_in_matrix = closes_matrix ? 8'd0 : elems_in_matrix + 8'd1;
    if (byte_ready) begin
      word_out.data = byte_acc;
      word_out.last = closes_matrix;
      due_bytes.push_back(word_out);
      byte_acc = '0;
      acc_fill = 0;
    end
  endtask

  // random element, biased towards the rounding and bias boundaries
  function automatic element_word_t random_element();
    element_word_t        w;
    logic [ELEMENT_W-1:0] pivot;
    w.value = ELEMENT_W'($urandom);
    w.hint  = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 3))
      2: begin
        case ($urandom_range(0, 7))
          0: pivot = ROUND_HALF - 1'b1;
          1: pivot = ROUND_HALF;
          2: pivot = BIAS_STEP - 1'b1;
          3: pivot = BIAS_STEP;
          4: pivot = ELEMENT_W'(3 * BIAS_STEP - 1);
          5: pivot = ELEMENT_W'(3 * BIAS_STEP);
          6: pivot = '0;
          default: pivot = LOW_MASK;
        endcase
        w.value = (w.value & ~LOW_MASK) | (pivot & LOW_MASK);
      end
      3: begin
        case ($urandom_range(0, 3))
          0: w.value = '0;
          1: w.value = '1;
          2: w.value = ~LOW_MASK;
          default: w.value = LOW_MASK;
        endcase
      end
      default: ;
    endcase
    return w;
  endfunction

  // apb write of the mode register, then read back
  task automatic set_mode(input logic [MODE_W-1:0] m);
    logic [APB_DW-1:0] readback;
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {lkrp_pkg::REG_MODE, 2'b00};
    pwdata  <= APB_DW'(m);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    shadow_mode = m;
    @(posedge clk);
    psel    <= 1'b1;
    paddr   <= {lkrp_pkg::REG_MODE, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    readback = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if (readback[MODE_W-1:0] !== m)
      flag_mismatch($sformatf("mode read back %0d, written %0d", readback[MODE_W-1:0], m));
  endtask

  task automatic queue_element(input logic [ELEMENT_W-1:0] v, input logic h);
    element_word_t w;
    w.value = v;
    w.hint  = h;
    pending_elements.push_back(w);
  endtask

  // block is idle once every word is sent and every byte has come out
  task automatic wait_idle();
    do @(posedge clk);
    while (pending_elements.size() != 0 || in_valid || due_bytes.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // input driver: bursts, gaps and the odd pause until all bytes are out
  int            burst_left = 1;
  int            gap_left = 0;
  int            bursts_seen = 0;
  bit            waiting_drain = 1'b0;
  element_word_t next_word;

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall)
        pack_element(element, hint);
      if (!in_valid || !in_stall) begin
        if (waiting_drain && due_bytes.size() == 0)
          waiting_drain = 1'b0;
        if (gap_left != 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (waiting_drain || pending_elements.size() == 0) begin
          in_valid <= 1'b0;
        end else begin
          next_word = pending_elements.pop_front();
          element  <= next_word.value;
          hint     <= next_word.hint;
          in_valid <= 1'b1;
          if (burst_left <= 1) begin
            bursts_seen++;
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 24);
            gap_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                   : $urandom_range(0, 4);
            waiting_drain = (bursts_seen == 4) || ($urandom_range(0, 19) == 0);
          end else begin
            burst_left--;
          end
        end
      end
    end
  end

  // output monitor with its own stall pattern
  int           stall_style = 0;
  int           style_left = 0;
  int           stall_run = 0;
  int unsigned  tick = 0;
  logic         stall_next;
  packed_byte_t want;

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (due_bytes.size() == 0) begin
          flag_mismatch($sformatf("byte %02h last %0b with nothing due", out_byte, last_byte));
        end else begin
          want = due_bytes.pop_front();
          if (out_byte !== want.data)
            flag_mismatch($sformatf("out_byte %02h, due %02h", out_byte, want.data));
          if (last_byte !== want.last)
            flag_mismatch($sformatf("last_byte %0b, due %0b (byte %02h)",
                                    last_byte, want.last, want.data));
        end
      end
      tick++;
      if (style_left == 0) begin
        stall_style = $urandom_range(0, 3);
        style_left  = $urandom_range(32, 400);
      end
      style_left--;
      case (stall_style)
        0: stall_next = 1'b0;
        1: stall_next = 1'($urandom_range(0, 1));
        2: stall_next = (tick % 5) < 2;
        default: begin
          if (stall_run > 0) begin
            stall_run--;
            stall_next = 1'b1;
          end else if ($urandom_range(0, 15) == 0) begin
            stall_run  = $urandom_range(1, 20);
            stall_next = 1'b1;
          end else begin
            stall_next = 1'b0;
          end
        end
      endcase
      out_stall <= stall_next;
    end
  end

  // stimulus sequence
  int               words_left;
  int               phase_len;
  int               phase_no;
  logic [MODE_W-1:0] phase_mode;
  element_word_t    w;

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // hint mode straight from reset: bit extremes, one full byte
    queue_element(16'h0000, 1'b0);
    queue_element(16'hFFFF, 1'b1);
    queue_element(16'h0400, 1'b0);
    queue_element(16'h03FF, 1'b1);
    queue_element(16'h0800, 1'b0);
    queue_element(16'hFBFF, 1'b1);
    queue_element(16'h0600, 1'b0);
    queue_element(16'h0200, 1'b1);
    wait_idle();

    // plain rounding incl. wrap at the top, odd count leaves half a byte
    set_mode(lkrp_pkg::MODE_KEY);
    queue_element(16'hFFFF, 1'b0);
    queue_element(16'h0000, 1'b1);
    queue_element(16'h03FF, 1'b0);
    queue_element(16'h0400, 1'b1);
    queue_element(16'h77FF, 1'b0);
    wait_idle();

    // rounding with hint: both bias signs, no-bias and wrap cases
    set_mode(lkrp_pkg::MODE_KEY_HINT);
    queue_element(16'h0200, 1'b1);
    queue_element(16'h0200, 1'b0);
    queue_element(16'h0400, 1'b0);
    queue_element(16'h0400, 1'b1);
    queue_element(16'h0600, 1'b1);
    queue_element(16'hFDFF, 1'b1);
    wait_idle();

    // unused code
    set_mode(MODE_UNUSED);
    queue_element(16'h1234, 1'b1);
    queue_element(16'hFC00, 1'b0);
    wait_idle();

    // random phases, each under a fresh mode and ending anywhere in a matrix
    words_left = RANDOM_WORDS;
    phase_no   = 0;
    while (words_left > 0) begin
      phase_len = ($urandom_range(0, 4) == 0) ? $urandom_range(150, 400)
                                              : $urandom_range(5, 120);
      if (phase_len > words_left)
        phase_len = words_left;
      case ($urandom_range(0, 9))
        0, 1, 2: phase_mode = lkrp_pkg::MODE_HINT;
        3, 4, 5: phase_mode = lkrp_pkg::MODE_KEY;
        6, 7, 8: phase_mode = lkrp_pkg::MODE_KEY_HINT;
        default: phase_mode = MODE_UNUSED;
      endcase
      if (phase_no == 0)
        phase_mode = lkrp_pkg::MODE_HINT;
      set_mode(phase_mode);
      repeat (phase_len) begin
        w = random_element();
        pending_elements.push_back(w);
      end
      wait_idle();
      words_left -= phase_len;
      phase_no++;
    end

    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2000000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
